### rtl/efla_pkg.sv
// Shared types and constants for the explicit free-list allocator.
`default_nettype none
package efla_pkg;

   typedef enum logic [5:0] {
      S_IDLE,
      S_AL_START,
      S_FF_HDR,
      S_FF_NXT,
      S_GR_CHK,
      S_GR_EPI,
      S_FR_RD,
      S_MG_PB,
      S_MG_SZ,
      S_MG_PA,
      S_MG_NA,
      S_MG_DEC,
      S_MG_UL2,
      S_MG_T,
      S_MG_PUSH,
      S_MG_END,
      S_PL_RD,
      S_PL_SPLIT,
      S_PL_REM,
      S_PL_PUSH,
      S_UL_S,
      S_UL_H,
      S_UL_P,
      S_UL_W1,
      S_UL_W2,
      S_TG_1,
      S_TG_2,
      S_PU_1,
      S_PU_2,
      S_PU_3,
      S_DONE
   } state_type;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_OOM  = 2'd2;

   localparam logic [31:0] PROLOGUE_BP = 32'd8;
   localparam logic [31:0] FIRST_BP    = 32'd24;
   localparam logic [31:0] MIN_BLOCK   = 32'd16;
   localparam logic [31:0] PRO_TAG     = 32'd17;

   // one access to the heap memory, issued with go high for one cycle
   typedef struct packed {
      logic        go;
      logic        we;
      logic [31:0] addr;
      logic [31:0] wdata;
   } mem_req_type;

   typedef struct packed {
      logic        ready;
      logic        done;
      logic [31:0] rdata;
   } mem_rsp_type;

endpackage
`default_nettype wire

### rtl/efla_mem.sv
// Heap word memory with byte-address reduction unit and post-reset init sweep.
`default_nettype none
module efla_mem #(
   parameter int unsigned HEAP_BYTES  = 65536,
   parameter int unsigned CHUNK_BYTES = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire efla_pkg::mem_req_type mem_req,
   output      efla_pkg::mem_rsp_type mem_rsp
);
   import efla_pkg::*;

   localparam int unsigned WORDS = HEAP_BYTES / 4;
   localparam int unsigned IW    = $clog2(WORDS);
   localparam int unsigned SH    = 30 + IW;
   localparam logic [63:0] RECIP64 = (64'd1 << SH) / WORDS;
   localparam logic [30:0] RECIP   = RECIP64[30:0];
   localparam logic [29:0] WORDS30 = 30'(WORDS);
   localparam int unsigned CQ    = (CHUNK_BYTES / 8) * 8;
   localparam bit          FIT   = (24 + 2 * CQ) <= (WORDS * 4);
   localparam int unsigned W_FTR = (16 + 2 * CQ) / 4;
   localparam int unsigned W_EPI = (20 + 2 * CQ) / 4;

   logic [31:0] heap_mem [WORDS];

   logic          clr_active_ff;
   logic [IW-1:0] clr_idx_ff;
   logic          v1_ff, v2_ff, v3_ff, done_ff;
   logic          we_ff;
   logic [31:0]   wdata_ff;
   logic [29:0]   x_ff, q_ff, qn_ff;
   logic [31:0]   rdata_ff;

   logic [60:0]   prod;
   logic [29:0]   q_in, qn_in, r_raw, r_fix;
   logic [IW-1:0] idx;
   logic [31:0]   init_word;

   // word index = (addr >> 2) mod WORDS, by reciprocal multiply and one correction
   assign prod  = 61'(x_ff) * 61'(RECIP);
   assign q_in  = 30'(prod >> SH);
   assign qn_in = q_ff * WORDS30;
   assign r_raw = x_ff - qn_ff;
   assign r_fix = (r_raw >= WORDS30) ? (r_raw - WORDS30) : r_raw;
   assign idx   = r_fix[IW-1:0];

   always_comb begin
      init_word = '0;
      priority if (clr_idx_ff == IW'(1) || clr_idx_ff == IW'(4)) begin
         init_word = PRO_TAG;
      end else if (clr_idx_ff == IW'(5)) begin
         init_word = FIT ? 32'(2 * CQ) : 32'd1;
      end else if (FIT && clr_idx_ff == IW'(2)) begin
         init_word = FIRST_BP;
      end else if (FIT && clr_idx_ff == IW'(7)) begin
         init_word = PROLOGUE_BP;
      end else if (FIT && clr_idx_ff == IW'(W_FTR)) begin
         init_word = 32'(2 * CQ);
      end else if (FIT && clr_idx_ff == IW'(W_EPI)) begin
         init_word = 32'd1;
      end else begin
         init_word = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         if (clr_active_ff) begin
            if (clr_idx_ff == IW'(WORDS - 1)) begin
               clr_active_ff <= 1'b0;
            end else begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
            end
         end
         v1_ff   <= mem_req.go;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         done_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.go) begin
         x_ff     <= mem_req.addr[31:2];
         we_ff    <= mem_req.we;
         wdata_ff <= mem_req.wdata;
      end
      q_ff  <= q_in;
      qn_ff <= qn_in;
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         heap_mem[clr_idx_ff] <= init_word;
      end else if (v3_ff && we_ff) begin
         heap_mem[idx] <= wdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v3_ff && !we_ff) begin
         rdata_ff <= heap_mem[idx];
      end
   end

   assign mem_rsp.ready = !clr_active_ff;
   assign mem_rsp.done  = done_ff;
   assign mem_rsp.rdata = rdata_ff;

endmodule
`default_nettype wire

### rtl/explicit_free_list_allocator.sv
// Top level: boundary-tag heap allocator sequencer around the heap memory.
//
//  channel | direction | handshake               | payload
//  req     | in        | req_tvalid/req_tready   | tuser: req_type; tdata: req_size, block_addr
//  rsp     | out       | rsp_tvalid/rsp_tready   | tdata: payload_addr, status
//
// Every heap word access goes through the one memory port (address
// reduction, access, registered read data). An allocate walks the free list
// block by block and grows the heap when the walk finds no fitting block.
// After reset a sweep over all HEAP_BYTES/4 words loads the heap image, with
// req_tready low. One word is handled at a time; a finished result waits in
// the output register while the next word is accepted.
`default_nettype none
module explicit_free_list_allocator #(
   parameter int unsigned HEAP_BYTES  = 65536,
   parameter int unsigned CHUNK_BYTES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [39:0] req_tdata,   // [16:0] req_size, [32:17] block_addr
   input  wire logic        req_tuser,   // [0] req_type
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata    // [15:0] payload_addr, [17:16] status
);
   import efla_pkg::*;

   localparam int unsigned WORDS    = HEAP_BYTES / 4;
   localparam int unsigned LIMIT    = WORDS * 4;
   localparam int unsigned BW       = $clog2(LIMIT + 1);
   localparam int unsigned CQ       = (CHUNK_BYTES / 8) * 8;
   localparam bit          FIT      = (24 + 2 * CQ) <= LIMIT;
   localparam int unsigned WALK_MAX = WORDS / 4 + 2;
   localparam int unsigned WCW      = $clog2(WALK_MAX + 1);

   mem_req_type mem_req;
   mem_rsp_type mem_rsp;

   efla_mem #(
      .HEAP_BYTES (HEAP_BYTES),
      .CHUNK_BYTES(CHUNK_BYTES)
   ) u_mem (
      .clock  (clock),
      .reset  (reset),
      .mem_req(mem_req),
      .mem_rsp(mem_rsp)
   );

   logic        req_type;
   logic [16:0] req_size;
   logic [15:0] block_addr;
   assign req_type   = req_tuser;
   assign req_size   = req_tdata[16:0];
   assign block_addr = req_tdata[32:17];

   // control
   state_type state_ff, state_in;
   state_type ul_ret_ff, ul_ret_in, tg_ret_ff, tg_ret_in, pu_ret_ff, pu_ret_in;
   logic      issued_ff, issued_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [31:0]   head_ff, head_in;
   logic [BW-1:0] brk_ff, brk_in;
   logic [WCW-1:0] n_ff, n_in;

   // datapath
   logic        is_free_ff, is_free_in;
   logic [16:0] size_ff, size_in;
   logic [17:0] asize_ff, asize_in;   // rounded size can pass 17 bits
   logic [15:0] blk_ff, blk_in;
   logic [31:0] bp_ff, bp_in, pb_ff, pb_in, nb_ff, nb_in;
   logic [31:0] psz_ff, psz_in, nsz_ff, nsz_in, sz_ff, sz_in;
   logic        pa_ff, pa_in, na_ff, na_in;
   logic [31:0] s_ff, s_in, p_ff, p_in, ul_x_ff, ul_x_in;
   logic [31:0] tg_sz_ff, tg_sz_in;
   logic        tg_al_ff, tg_al_in;
   logic [15:0] res_addr_ff, res_addr_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic [23:0] rsp_data_ff, rsp_data_in;

   logic        mem_go;
   logic [31:0] masked, asz32, ext32;
   logic [32:0] grown;
   logic [17:0] size_up;

   assign masked  = {mem_rsp.rdata[31:3], 3'b000};
   assign asz32   = 32'(asize_ff);
   assign ext32   = (asz32 > 32'(CQ)) ? asz32 : 32'(CQ);
   assign grown   = 33'(brk_ff) + 33'(ext32);
   assign size_up = 18'(req_size) + 18'd15;

   assign req_tready = (state_ff == S_IDLE) && mem_rsp.ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      ul_ret_in     = ul_ret_ff;
      tg_ret_in     = tg_ret_ff;
      pu_ret_in     = pu_ret_ff;
      head_in       = head_ff;
      brk_in        = brk_ff;
      n_in          = n_ff;
      is_free_in    = is_free_ff;
      size_in       = size_ff;
      asize_in      = asize_ff;
      blk_in        = blk_ff;
      bp_in         = bp_ff;
      pb_in         = pb_ff;
      nb_in         = nb_ff;
      psz_in        = psz_ff;
      nsz_in        = nsz_ff;
      sz_in         = sz_ff;
      pa_in         = pa_ff;
      na_in         = na_ff;
      s_in          = s_ff;
      p_in          = p_ff;
      ul_x_in       = ul_x_ff;
      tg_sz_in      = tg_sz_ff;
      tg_al_in      = tg_al_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      mem_go        = 1'b0;
      mem_req.we    = 1'b0;
      mem_req.addr  = '0;
      mem_req.wdata = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               is_free_in    = (req_type == REQ_FREE);
               size_in       = req_size;
               blk_in        = block_addr;
               asize_in      = (req_size <= 17'd8) ? 18'd16 : {size_up[17:3], 3'b000};
               res_addr_in   = '0;
               res_status_in = ST_OK;
               state_in      = (req_type == REQ_FREE) ? S_FR_RD : S_AL_START;
            end
         end
         S_AL_START: begin
            if (size_ff == '0) begin
               res_status_in = ST_ZERO;
               state_in      = S_DONE;
            end else begin
               bp_in    = head_ff;
               n_in     = '0;
               state_in = S_FF_HDR;
            end
         end
         // first-fit walk: header check, then successor link
         S_FF_HDR: begin
            if (n_ff == WCW'(WALK_MAX)) begin
               state_in = S_GR_CHK;
            end else begin
               mem_go       = 1'b1;
               mem_req.addr = bp_ff - 32'd4;
               if (mem_rsp.done) begin
                  priority if (mem_rsp.rdata[0]) begin
                     state_in = S_GR_CHK;
                  end else if (masked >= asz32) begin
                     state_in = (bp_ff == '0) ? S_GR_CHK : S_PL_RD;
                  end else begin
                     state_in = S_FF_NXT;
                  end
               end
            end
         end
         S_FF_NXT: begin
            mem_go       = 1'b1;
            mem_req.addr = bp_ff + 32'd4;
            if (mem_rsp.done) begin
               bp_in    = mem_rsp.rdata;
               n_in     = n_ff + 1'b1;
               state_in = S_FF_HDR;
            end
         end
         // heap growth by max(asize, chunk)
         S_GR_CHK: begin
            if (grown > 33'(LIMIT)) begin
               res_status_in = ST_OOM;
               state_in      = S_DONE;
            end else begin
               bp_in     = 32'(brk_ff);
               brk_in    = BW'(grown);
               tg_sz_in  = ext32;
               tg_al_in  = 1'b0;
               tg_ret_in = S_GR_EPI;
               state_in  = S_TG_1;
            end
         end
         S_GR_EPI: begin
            mem_go        = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = bp_ff + tg_sz_ff - 32'd4;
            mem_req.wdata = 32'd1;
            if (mem_rsp.done) begin
               state_in = S_MG_PB;
            end
         end
         S_FR_RD: begin
            if (blk_ff >= 16'd24 && 32'(blk_ff) < 32'(brk_ff) && blk_ff[2:0] == 3'b000) begin
               mem_go       = 1'b1;
               mem_req.addr = 32'(blk_ff) - 32'd4;
               if (mem_rsp.done) begin
                  if (mem_rsp.rdata[0]) begin
                     bp_in     = 32'(blk_ff);
                     tg_sz_in  = masked;
                     tg_al_in  = 1'b0;
                     tg_ret_in = S_MG_PB;
                     state_in  = S_TG_1;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end else begin
               state_in = S_DONE;
            end
         end
         // coalesce: gather neighbor tags, then unlink, retag, push
         S_MG_PB: begin
            mem_go       = 1'b1;
            mem_req.addr = bp_ff - 32'd8;
            if (mem_rsp.done) begin
               pb_in    = bp_ff - masked;
               state_in = S_MG_SZ;
            end
         end
         S_MG_SZ: begin
            mem_go       = 1'b1;
            mem_req.addr = bp_ff - 32'd4;
            if (mem_rsp.done) begin
               sz_in    = masked;
               nb_in    = bp_ff + masked;
               state_in = S_MG_PA;
            end
         end
         S_MG_PA: begin
            mem_go       = 1'b1;
            mem_req.addr = pb_ff - 32'd4;
            if (mem_rsp.done) begin
               pa_in    = mem_rsp.rdata[0];
               psz_in   = masked;
               state_in = S_MG_NA;
            end
         end
         S_MG_NA: begin
            mem_go       = 1'b1;
            mem_req.addr = nb_ff - 32'd4;
            if (mem_rsp.done) begin
               na_in    = mem_rsp.rdata[0];
               nsz_in   = masked;
               state_in = S_MG_DEC;
            end
         end
         S_MG_DEC: begin
            unique case ({pa_ff, na_ff})
               2'b10: begin
                  ul_x_in   = nb_ff;
                  ul_ret_in = S_MG_T;
                  sz_in     = sz_ff + nsz_ff;
                  state_in  = S_UL_S;
               end
               2'b01: begin
                  ul_x_in   = pb_ff;
                  ul_ret_in = S_MG_T;
                  sz_in     = sz_ff + psz_ff;
                  bp_in     = pb_ff;
                  state_in  = S_UL_S;
               end
               2'b00: begin
                  ul_x_in   = pb_ff;
                  ul_ret_in = S_MG_UL2;
                  sz_in     = sz_ff + psz_ff + nsz_ff;
                  bp_in     = pb_ff;
                  state_in  = S_UL_S;
               end
               default: begin
                  state_in = S_MG_PUSH;
               end
            endcase
         end
         S_MG_UL2: begin
            ul_x_in   = nb_ff;
            ul_ret_in = S_MG_T;
            state_in  = S_UL_S;
         end
         S_MG_T: begin
            tg_sz_in  = sz_ff;
            tg_al_in  = 1'b0;
            tg_ret_in = S_MG_PUSH;
            state_in  = S_TG_1;
         end
         S_MG_PUSH: begin
            pu_ret_in = S_MG_END;
            state_in  = S_PU_1;
         end
         S_MG_END: begin
            priority if (is_free_ff) begin
               state_in = S_DONE;
            end else if (bp_ff == '0) begin
               res_status_in = ST_OOM;
               state_in      = S_DONE;
            end else begin
               state_in = S_PL_RD;
            end
         end
         // place: unlink, mark allocated, split off a remainder of 16+ bytes
         S_PL_RD: begin
            mem_go       = 1'b1;
            mem_req.addr = bp_ff - 32'd4;
            if (mem_rsp.done) begin
               sz_in       = masked;
               res_addr_in = bp_ff[15:0];
               ul_x_in     = bp_ff;
               ul_ret_in   = S_PL_SPLIT;
               state_in    = S_UL_S;
            end
         end
         S_PL_SPLIT: begin
            tg_al_in = 1'b1;
            state_in = S_TG_1;
            if (sz_ff >= asz32 && (sz_ff - asz32) >= MIN_BLOCK) begin
               tg_sz_in  = asz32;
               tg_ret_in = S_PL_REM;
            end else begin
               tg_sz_in  = sz_ff;
               tg_ret_in = S_DONE;
            end
         end
         S_PL_REM: begin
            bp_in     = bp_ff + asz32;
            tg_sz_in  = sz_ff - asz32;
            tg_al_in  = 1'b0;
            tg_ret_in = S_PL_PUSH;
            state_in  = S_TG_1;
         end
         S_PL_PUSH: begin
            pu_ret_in = S_DONE;
            state_in  = S_PU_1;
         end
         // unlink ul_x from the list
         S_UL_S: begin
            mem_go       = 1'b1;
            mem_req.addr = ul_x_ff + 32'd4;
            if (mem_rsp.done) begin
               s_in     = mem_rsp.rdata;
               state_in = (ul_x_ff == head_ff) ? S_UL_H : S_UL_P;
            end
         end
         S_UL_H: begin
            mem_go       = 1'b1;
            mem_req.we   = 1'b1;
            mem_req.addr = s_ff;
            if (mem_rsp.done) begin
               head_in  = s_ff;
               state_in = ul_ret_ff;
            end
         end
         S_UL_P: begin
            mem_go       = 1'b1;
            mem_req.addr = ul_x_ff;
            if (mem_rsp.done) begin
               p_in     = mem_rsp.rdata;
               state_in = S_UL_W1;
            end
         end
         S_UL_W1: begin
            mem_go        = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = p_ff + 32'd4;
            mem_req.wdata = s_ff;
            if (mem_rsp.done) begin
               state_in = S_UL_W2;
            end
         end
         S_UL_W2: begin
            mem_go        = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = s_ff;
            mem_req.wdata = p_ff;
            if (mem_rsp.done) begin
               state_in = ul_ret_ff;
            end
         end
         // header and footer of the block at bp
         S_TG_1: begin
            mem_go        = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = bp_ff - 32'd4;
            mem_req.wdata = tg_sz_ff | 32'(tg_al_ff);
            if (mem_rsp.done) begin
               state_in = S_TG_2;
            end
         end
         S_TG_2: begin
            mem_go        = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = bp_ff + tg_sz_ff - 32'd8;
            mem_req.wdata = tg_sz_ff | 32'(tg_al_ff);
            if (mem_rsp.done) begin
               state_in = tg_ret_ff;
            end
         end
         // push bp on the list head
         S_PU_1: begin
            mem_go        = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = bp_ff + 32'd4;
            mem_req.wdata = head_ff;
            if (mem_rsp.done) begin
               state_in = S_PU_2;
            end
         end
         S_PU_2: begin
            mem_go       = 1'b1;
            mem_req.we   = 1'b1;
            mem_req.addr = bp_ff;
            if (mem_rsp.done) begin
               state_in = S_PU_3;
            end
         end
         S_PU_3: begin
            mem_go        = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = head_ff;
            mem_req.wdata = bp_ff;
            if (mem_rsp.done) begin
               head_in  = bp_ff;
               state_in = pu_ret_ff;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b000000, res_status_ff, res_addr_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // one access outstanding; go pulses on the first cycle of a memory state
      mem_req.go = mem_go && !issued_ff;
      issued_in  = mem_go && !mem_rsp.done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ul_ret_ff    <= S_IDLE;
         tg_ret_ff    <= S_IDLE;
         pu_ret_ff    <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= FIT ? FIRST_BP : PROLOGUE_BP;
         brk_ff       <= BW'(FIT ? (24 + 2 * CQ) : 24);
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         ul_ret_ff    <= ul_ret_in;
         tg_ret_ff    <= tg_ret_in;
         pu_ret_ff    <= pu_ret_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         brk_ff       <= brk_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      is_free_ff    <= is_free_in;
      size_ff       <= size_in;
      asize_ff      <= asize_in;
      blk_ff        <= blk_in;
      bp_ff         <= bp_in;
      pb_ff         <= pb_in;
      nb_ff         <= nb_in;
      psz_ff        <= psz_in;
      nsz_ff        <= nsz_in;
      sz_ff         <= sz_in;
      pa_ff         <= pa_in;
      na_ff         <= na_in;
      s_ff          <= s_in;
      p_ff          <= p_in;
      ul_x_ff       <= ul_x_in;
      tg_sz_ff      <= tg_sz_in;
      tg_al_ff      <= tg_al_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule
`default_nettype wire

### tb/tb_explicit_free_list_allocator.sv
// Testbench for explicit_free_list_allocator: directed table, then random traffic, checked against a heap model.
`timescale 1ns / 1ps
`default_nettype none
module tb_explicit_free_list_allocator;
   import efla_pkg::*;

   localparam int unsigned HEAP_BYTES  = 65536;
   localparam int unsigned CHUNK_BYTES = 4096;
   localparam int unsigned HEAP_WORDS  = HEAP_BYTES / 4;
   localparam int unsigned CHUNK_Q     = CHUNK_BYTES & ~32'd7;
   localparam int unsigned WALK_LIMIT  = HEAP_WORDS / 4 + 2;
   localparam int unsigned N_RANDOM    = 400;
   // worst list walks are thousands of memory accesses; stay generous
   localparam longint     CYCLE_LIMIT = 10000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [16:0] req_size, [32:17] block_addr
   logic        req_tuser = 1'b0; // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [15:0] payload_addr, [17:16] status

   explicit_free_list_allocator #(
      .HEAP_BYTES (HEAP_BYTES),
      .CHUNK_BYTES(CHUNK_BYTES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #2 clock = ~clock;

   typedef struct packed {
      logic [15:0] payload;
      logic [1:0]  status;
   } reply_type;

   reply_type   pending_replies[$];
   int          fails = 0;
   longint      cycles = 0;
   bit          calm = 1'b0;      // no idling on either side while set
   bit          hold_rsp = 1'b0;  // one long receiver hold-off

   // ---------------------------------------------------------------
   // Heap shadow: word image, free-list head and break
   // ---------------------------------------------------------------
   logic [31:0] heap_img [HEAP_WORDS];
   int unsigned free_head;
   int unsigned brk;

   function automatic logic [31:0] hrd(int unsigned a);
      return heap_img[(a >> 2) % HEAP_WORDS];
   endfunction

   function automatic void hwr(int unsigned a, logic [31:0] v);
      heap_img[(a >> 2) % HEAP_WORDS] = v;
   endfunction

   function automatic int unsigned blk_size(int unsigned bp);
      return hrd(bp - 4) & ~32'd7;
   endfunction

   function automatic bit blk_used(int unsigned bp);
      return bit'(hrd(bp - 4) & 32'd1);
   endfunction

   function automatic void write_tags(int unsigned bp, int unsigned sz, bit used);
      hwr(bp - 4, sz | used);
      hwr(bp + sz - 8, sz | used);
   endfunction

   function automatic void push_free(int unsigned bp);
      hwr(bp + 4, free_head);
      hwr(bp, 0);
      hwr(free_head, bp);
      free_head = bp;
   endfunction

   function automatic void unlink_free(int unsigned bp);
      int unsigned s, p;
      s = hrd(bp + 4);
      if (bp == free_head) begin
         hwr(s, 0);
         free_head = s;
      end else begin
         p = hrd(bp);
         hwr(p + 4, s);
         hwr(s, p);
      end
   endfunction

   function automatic int unsigned coalesce(int unsigned bp);
      int unsigned pb, nb, sz, psz, nsz;
      bit pa, na;
      pb  = bp - (hrd(bp - 8) & ~32'd7);
      nb  = bp + blk_size(bp);
      pa  = blk_used(pb);
      na  = blk_used(nb);
      sz  = blk_size(bp);
      psz = blk_size(pb);
      nsz = blk_size(nb);
      if (pa && !na) begin
         unlink_free(nb);
         sz += nsz;
         write_tags(bp, sz, 1'b0);
      end else if (!pa && na) begin
         unlink_free(pb);
         sz += psz;
         bp = pb;
         write_tags(bp, sz, 1'b0);
      end else if (!pa && !na) begin
         unlink_free(pb);
         unlink_free(nb);
         sz += psz + nsz;
         bp = pb;
         write_tags(bp, sz, 1'b0);
      end
      push_free(bp);
      return bp;
   endfunction

   // 0 when the heap cannot grow by sz
   function automatic int unsigned grow_heap(int unsigned sz);
      int unsigned bp;
      bp = brk;
      if (longint'(brk) + longint'(sz) > longint'(HEAP_BYTES)) return 0;
      brk += sz;
      write_tags(bp, sz, 1'b0);
      hwr(bp + sz - 4, 1);
      return coalesce(bp);
   endfunction

   // list walk ends at the first fit, at the prologue (allocated) or after WALK_LIMIT steps
   function automatic int unsigned walk_list(int unsigned asz);
      int unsigned bp;
      bp = free_head;
      for (int unsigned n = 0; n < WALK_LIMIT; n++) begin
         if (blk_used(bp)) return 0;
         if (blk_size(bp) >= asz) return bp;
         bp = hrd(bp + 4);
      end
      return 0;
   endfunction

   function automatic void carve(int unsigned bp, int unsigned asz);
      int unsigned csz;
      csz = blk_size(bp);
      unlink_free(bp);
      if (csz >= asz && csz - asz >= 16) begin
         write_tags(bp, asz, 1'b1);
         write_tags(bp + asz, csz - asz, 1'b0);
         push_free(bp + asz);
      end else begin
         write_tags(bp, csz, 1'b1);
      end
   endfunction

   function automatic void heap_init();
      foreach (heap_img[i]) heap_img[i] = '0;
      hwr(4, 17);
      hwr(16, 17);
      hwr(20, 1);
      free_head = 8;
      brk = 24;
      void'(grow_heap(2 * CHUNK_Q));
   endfunction

   function automatic reply_type heap_request(logic kind, logic [16:0] sz, logic [15:0] addr);
      reply_type r;
      int unsigned asz, bp, ext;
      r = '{payload: '0, status: ST_OK};
      if (kind == REQ_ALLOC) begin
         if (sz == 0) begin
            r.status = ST_ZERO;
         end else begin
            asz = (sz <= 8) ? 16 : 8 * ((int'(sz) + 15) / 8);
            bp = walk_list(asz);
            if (bp == 0) begin
               ext = (asz > CHUNK_Q) ? asz : CHUNK_Q;
               bp = grow_heap(ext);
            end
            if (bp == 0) begin
               r.status = ST_OOM;
            end else begin
               carve(bp, asz);
               r.payload = bp[15:0];
            end
         end
      end else if (addr >= 24 && addr < brk && addr[2:0] == 3'd0 && blk_used(addr)) begin
         // bad frees fall through untouched
         write_tags(addr, blk_size(addr), 1'b0);
         void'(coalesce(addr));
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Sender: one word per call, valid held across back-to-back words
   // ---------------------------------------------------------------
   task automatic send_word(logic kind, logic [16:0] sz, logic [15:0] addr);
      bit taken;
      if (!calm && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, addr, sz};
      do begin
         #1 taken = req_tready;   // value seen by the coming rising edge
         @(negedge clock);
      end while (!taken);
   endtask

   // Receiver: random stalls plus one long hold-off while the sender keeps pushing
   always @(negedge clock) begin
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
         repeat (400) @(negedge clock);
         hold_rsp = 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 24);
      end
   end

   // Response check, sampled just ahead of the rising edge
   always @(negedge clock) begin
      reply_type want;
      #1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected response word %h", rsp_tdata);
            fails++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_tdata[15:0] !== want.payload) begin
               $error("payload_addr expected %0d got %0d", want.payload, rsp_tdata[15:0]);
               fails++;
            end
            if (rsp_tdata[17:16] !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_tdata[17:16]);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_explicit_free_list_allocator failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Directed table: typed expectation where it is obvious, else model
   // ---------------------------------------------------------------
   typedef struct {
      logic        kind;
      logic [16:0] sz;
      logic [15:0] addr;
      bit          typed;
      logic [15:0] payload;
      logic [1:0]  status;
   } step_type;

   step_type directed[] = '{
      '{REQ_ALLOC, 17'd1,      16'd0,     1, 16'd24, ST_OK},   // first fit from fresh chunk
      '{REQ_ALLOC, 17'd0,      16'd0,     1, 16'd0,  ST_ZERO},
      '{REQ_ALLOC, 17'd8,      16'd0,     1, 16'd40, ST_OK},
      '{REQ_ALLOC, 17'd9,      16'd0,     1, 16'd56, ST_OK},   // rounds to 24
      '{REQ_ALLOC, 17'd65536,  16'd0,     1, 16'd0,  ST_OOM},
      '{REQ_ALLOC, 17'd131071, 16'd0,     1, 16'd0,  ST_OOM},
      '{REQ_FREE,  17'd0,      16'd41,    1, 16'd0,  ST_OK},   // misaligned
      '{REQ_FREE,  17'd0,      16'd8,     1, 16'd0,  ST_OK},   // prologue
      '{REQ_FREE,  17'd0,      16'd0,     1, 16'd0,  ST_OK},
      '{REQ_FREE,  17'd0,      16'd65535, 1, 16'd0,  ST_OK},   // past break
      '{REQ_FREE,  17'd0,      16'd24,    1, 16'd0,  ST_OK},
      '{REQ_FREE,  17'd0,      16'd24,    1, 16'd0,  ST_OK},   // double free
      '{REQ_FREE,  17'd131071, 16'd56,    1, 16'd0,  ST_OK},   // merges with the free block after it
      '{REQ_FREE,  17'd0,      16'd40,    1, 16'd0,  ST_OK},
      '{REQ_ALLOC, 17'd16,     16'd0,     0, 16'd0,  ST_OK},
      '{REQ_ALLOC, 17'd100,    16'd65535, 0, 16'd0,  ST_OK},
      '{REQ_ALLOC, 17'd4096,   16'd0,     0, 16'd0,  ST_OK},
      '{REQ_ALLOC, 17'd8192,   16'd0,     0, 16'd0,  ST_OK},   // forces growth
      '{REQ_ALLOC, 17'd40000,  16'd0,     0, 16'd0,  ST_OK},
      '{REQ_ALLOC, 17'd24000,  16'd0,     0, 16'd0,  ST_OK}    // likely out of memory
   };

   initial begin
      int unsigned live[$];
      reply_type   r;
      logic        kind;
      logic [16:0] sz;
      logic [15:0] addr;
      int unsigned pick, roll;

      heap_init();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         r = heap_request(directed[i].kind, directed[i].sz, directed[i].addr);
         if (directed[i].typed) r = '{payload: directed[i].payload, status: directed[i].status};
         // typed blocks are freed by the table itself
         if (!directed[i].typed && directed[i].kind == REQ_ALLOC && r.status == ST_OK)
            live.push_back(r.payload);
         pending_replies.push_back(r);
         send_word(directed[i].kind, directed[i].sz, directed[i].addr);
      end

      hold_rsp = 1'b1;
      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= 180 && n < 260);
         roll = $urandom_range(99);
         addr = 16'($urandom);
         sz   = 17'($urandom);
         if (roll < 4) begin
            kind = REQ_ALLOC;
            sz   = '0;
         end else if (roll < 58) begin
            kind = REQ_ALLOC;
            pick = $urandom_range(99);
            if (pick < 70)      sz = 17'($urandom_range(64, 1));
            else if (pick < 90) sz = 17'($urandom_range(2000, 65));
            else if (pick < 96) sz = 17'($urandom_range(20000, 2001));
         end else begin
            kind = REQ_FREE;
            if (live.size() > 0 && $urandom_range(99) < 85) begin
               pick = $urandom_range(live.size() - 1);
               addr = 16'(live[pick]);
               live.delete(pick);
            end else if (live.size() > 0 && $urandom_range(1)) begin
               addr = 16'(live[$urandom_range(live.size() - 1)] + 4);
            end
         end
         r = heap_request(kind, sz, addr);
         if (kind == REQ_ALLOC && r.status == ST_OK) live.push_back(r.payload);
         pending_replies.push_back(r);
         send_word(kind, sz, addr);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      wait (pending_replies.size() == 0);
      repeat (300) @(posedge clock);
      if (fails == 0 && pending_replies.size() == 0) begin
         $display("tb_explicit_free_list_allocator passed");
      end else begin
         $display("tb_explicit_free_list_allocator failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

### explicit_free_list_allocator.f
rtl/efla_pkg.sv
rtl/efla_mem.sv
rtl/explicit_free_list_allocator.sv
tb/tb_explicit_free_list_allocator.sv
